// ----- hdl/serial_line_command_parser_top_assert.svh -----
// ----------------------------------------------------------------------------
// Serial line command parser assertion macros
// Concurrent assertion helpers; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_COMMAND_PARSER_TOP_ASSERT_SVH
`define SERIAL_LINE_COMMAND_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SLCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcp: implication check failed");
`define SLCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcp: next-cycle check failed");
`else
`define SLCP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLCP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/slcp_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial line command parser package
// Shared types, codes, character constants and the command name table.
// ----------------------------------------------------------------------------
package slcp_pkg;

    localparam int LINE_CAPACITY_DEF = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam int MAX_CMDS          = 16;
    localparam int CMD_CNT_W         = 5;
    localparam int NUM_NAMES         = 5;
    localparam int NAME_MAX          = 5;

    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_DEL = 8'h7F;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    localparam logic [2:0] CMD_HELLO   = 3'd0;
    localparam logic [2:0] CMD_WAVE    = 3'd1;
    localparam logic [2:0] CMD_SMILE   = 3'd2;
    localparam logic [2:0] CMD_SAD     = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;
    localparam logic [2:0] CMD_INVALID = 3'd5;

    typedef enum logic [1:0] {
        OP_PRINT,
        OP_ERASE,
        OP_LEND
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    function automatic logic [2:0] name_len(input logic [2:0] k);
        logic [2:0] len;
        case (k)
            CMD_HELLO: len = 3'd5;
            CMD_WAVE:  len = 3'd4;
            CMD_SMILE: len = 3'd5;
            CMD_SAD:   len = 3'd3;
            CMD_CLEAR: len = 3'd5;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [6:0] name_char(input logic [2:0] k, input logic [2:0] i);
        logic [6:0] c;
        c = 7'h00;
        case (k)
            CMD_HELLO: begin
                case (i)
                    3'd0: c = 7'h68; 3'd1: c = 7'h65; 3'd2: c = 7'h6C;
                    3'd3: c = 7'h6C; 3'd4: c = 7'h6F; default: c = 7'h00;
                endcase
            end
            CMD_WAVE: begin
                case (i)
                    3'd0: c = 7'h77; 3'd1: c = 7'h61; 3'd2: c = 7'h76;
                    3'd3: c = 7'h65; default: c = 7'h00;
                endcase
            end
            CMD_SMILE: begin
                case (i)
                    3'd0: c = 7'h73; 3'd1: c = 7'h6D; 3'd2: c = 7'h69;
                    3'd3: c = 7'h6C; 3'd4: c = 7'h65; default: c = 7'h00;
                endcase
            end
            CMD_SAD: begin
                case (i)
                    3'd0: c = 7'h73; 3'd1: c = 7'h61; 3'd2: c = 7'h64;
                    default: c = 7'h00;
                endcase
            end
            CMD_CLEAR: begin
                case (i)
                    3'd0: c = 7'h63; 3'd1: c = 7'h6C; 3'd2: c = 7'h65;
                    3'd3: c = 7'h61; 3'd4: c = 7'h72; default: c = 7'h00;
                endcase
            end
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] to_lower(input logic [6:0] c);
        return (c >= 7'h41 && c <= 7'h5A) ? c + 7'd32 : c;
    endfunction

endpackage

// ----- hdl/serial_line_command_parser_top.sv -----
// ----------------------------------------------------------------------------
// Serial line command parser
// Line editor with echo that turns typed words into command codes.
// ----------------------------------------------------------------------------
// Input channel s_*: one received byte per word. Printable bytes are stored
// and echoed, backspace or delete erases (BS SP BS echoed), CR or LF ends the
// line. Output channel m_*: echo characters (m_kind 0) and command codes
// (m_kind 1, one per word of the line, before the CR LF echo); m_last marks
// the final result of each input byte. cfg_wr_en/cfg_wr_data set echo on/off.
// A printable or erase byte passes the queue and the state register before
// the result register. With echo on, a printable byte echoes from ST_ECHO
// and an erase from ST_ER1 to ST_ER3. A line end leaves the queue in ST_IDLE;
// each stored character is read in ST_ADDR and ST_DATA through the single
// read port of the line store, each word ends in ST_TOKEN, and ST_FLUSH,
// with ST_CR and ST_LF when echo is on, finishes the line. A two-word queue
// decouples the input from the executing part, so bytes keep being taken
// while a line is scanned, until the queue fills. When the receiver stalls,
// the result register holds and the scan waits to hand over a command.
// Reset empties the line, clears the queue and output, and turns echo on.
// ----------------------------------------------------------------------------
`include "serial_line_command_parser_top_assert.svh"

module serial_line_command_parser_top import slcp_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_echo_char,
    output logic [2:0] m_command,
    output logic       m_last
);

    q_push_t  q_push;
    q_entry_t q_head;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;

    slcp_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push)
    );

    slcp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    slcp_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_echo_char (m_echo_char),
        .m_command   (m_command),
        .m_last      (m_last)
    );

    `SLCP_ASSERT_IMP(a_cmd_fields, aclk, aresetn, m_valid && m_kind == KIND_CMD, m_echo_char == 8'h00 && m_command <= CMD_INVALID)
    `SLCP_ASSERT_IMP(a_echo_fields, aclk, aresetn, m_valid && m_kind == KIND_ECHO, m_command == CMD_HELLO)
    `SLCP_ASSERT_IMP(a_lf_last, aclk, aresetn, m_valid && m_kind == KIND_ECHO && m_echo_char == CHAR_LF, m_last)
    `SLCP_ASSERT_NEXT(a_cr_then_lf, aclk, aresetn, m_valid && m_ready && m_kind == KIND_ECHO && m_echo_char == CHAR_CR, m_valid && m_echo_char == CHAR_LF && m_last)

endmodule

// ----- hdl/slcp_front.sv -----
// ----------------------------------------------------------------------------
// Serial line command parser front end
// Accepts received bytes, classifies them and pushes editor operations.
// ----------------------------------------------------------------------------
module slcp_front import slcp_pkg::*; (
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       q_full,
    output q_push_t    q_push
);

    logic keep;
    op_t  op;

    always_comb begin
        keep = 1'b1;
        op   = OP_PRINT;
        if (s_rx_byte == CHAR_CR || s_rx_byte == CHAR_LF) begin
            op = OP_LEND;
        end else if (s_rx_byte == CHAR_BS || s_rx_byte == CHAR_DEL) begin
            op = OP_ERASE;
        end else if (s_rx_byte >= CHAR_SP && s_rx_byte <= CHAR_TILDE) begin
            op = OP_PRINT;
        end else begin
            // drop control and high bytes
            keep = 1'b0;
        end
    end

    assign s_ready            = !q_full;
    assign q_push.valid       = s_valid && !q_full && keep;
    assign q_push.entry.op    = op;
    assign q_push.entry.data  = s_rx_byte;

endmodule

// ----- hdl/slcp_queue.sv -----
// ----------------------------------------------------------------------------
// Serial line command parser operation queue
// Short first-in first-out store between front end and back end.
// ----------------------------------------------------------------------------
module slcp_queue import slcp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  q_push_t  q_push,
    output logic     q_full,
    output logic     q_valid,
    output q_entry_t q_head,
    input  logic     q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    q_entry_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];
    assign do_push = q_push.valid && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

// ----- hdl/slcp_back.sv -----
// ----------------------------------------------------------------------------
// Serial line command parser back end
// Line store, editing, token scan with name matching, and the result register.
// ----------------------------------------------------------------------------
module slcp_back import slcp_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       q_valid,
    input  q_entry_t   q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_echo_char,
    output logic [2:0] m_command,
    output logic       m_last
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [CMD_CNT_W-1:0] CMDS_CAP = CMD_CNT_W'(MAX_CMDS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ECHO,
        ST_ER1,
        ST_ER2,
        ST_ER3,
        ST_ADDR,
        ST_DATA,
        ST_TOKEN,
        ST_FLUSH,
        ST_CR,
        ST_LF
    } state_t;

    logic [6:0] line_mem [LINE_CAPACITY];
    logic [6:0] rd_data_reg;
    logic       mem_we;

    state_t               state_reg, state_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     p_reg, p_next;
    logic [6:0]           ch_reg, ch_next;
    logic                 in_tok_reg, in_tok_next;
    logic [2:0]           tok_len_reg, tok_len_next;
    logic [NUM_NAMES-1:0] cand_reg, cand_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [2:0]           pend_code_reg, pend_code_next;
    logic [CMD_CNT_W-1:0] cmds_reg, cmds_next;
    logic                 echo_reg;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_kind_reg, m_kind_next;
    logic [7:0]           m_char_reg, m_char_next;
    logic [2:0]           m_cmd_reg, m_cmd_next;
    logic                 m_last_reg, m_last_next;

    logic                 out_free;
    logic [2:0]           tok_code;
    logic [6:0]           lc;
    logic [2:0]           idx;
    logic                 is_gap;
    logic [NUM_NAMES-1:0] cand_upd;
    logic [2:0]           tok_len_upd;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[len_reg] <= q_head.data[6:0];
        end
        rd_data_reg <= line_mem[p_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            echo_reg <= cfg_wr_data;
        end
    end

    // token code from the candidate set
    always_comb begin
        tok_code = CMD_INVALID;
        for (int k = NUM_NAMES - 1; k >= 0; k--) begin
            if (cand_reg[k] && tok_len_reg == name_len(3'(k))) begin
                tok_code = 3'(k);
            end
        end
    end

    // candidate update for one token character
    always_comb begin
        lc     = to_lower(rd_data_reg);
        idx    = in_tok_reg ? tok_len_reg : 3'd0;
        is_gap = ({1'b0, rd_data_reg} == CHAR_SP) || ({1'b0, rd_data_reg} == CHAR_TAB);
        for (int k = 0; k < NUM_NAMES; k++) begin
            cand_upd[k] = (in_tok_reg ? cand_reg[k] : 1'b1)
                          && (idx < name_len(3'(k)))
                          && (lc == name_char(3'(k), idx));
        end
        if (!in_tok_reg) begin
            tok_len_upd = 3'd1;
        end else if (tok_len_reg == 3'd7) begin
            tok_len_upd = 3'd7;
        end else begin
            tok_len_upd = tok_len_reg + 3'd1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        p_next          = p_reg;
        ch_next         = ch_reg;
        in_tok_next     = in_tok_reg;
        tok_len_next    = tok_len_reg;
        cand_next       = cand_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        cmds_next       = cmds_reg;
        m_valid_next    = out_free ? 1'b0 : m_valid_reg;
        m_kind_next     = m_kind_reg;
        m_char_next     = m_char_reg;
        m_cmd_next      = m_cmd_reg;
        m_last_next     = m_last_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        OP_PRINT: begin
                            if (len_reg != LEN_MAX) begin
                                mem_we   = 1'b1;
                                len_next = len_reg + 1'b1;
                                ch_next  = q_head.data[6:0];
                                if (echo_reg) begin
                                    state_next = ST_ECHO;
                                end
                            end
                        end
                        OP_ERASE: begin
                            if (len_reg != '0) begin
                                len_next = len_reg - 1'b1;
                                if (echo_reg) begin
                                    state_next = ST_ER1;
                                end
                            end
                        end
                        OP_LEND: begin
                            p_next          = '0;
                            in_tok_next     = 1'b0;
                            pend_valid_next = 1'b0;
                            cmds_next       = '0;
                            state_next      = ST_ADDR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_ECHO;
                    m_char_next  = {1'b0, ch_reg};
                    m_cmd_next   = 3'd0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ER1, ST_ER2, ST_ER3: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_ECHO;
                    m_cmd_next   = 3'd0;
                    m_char_next  = (state_reg == ST_ER2) ? CHAR_SP : CHAR_BS;
                    m_last_next  = (state_reg == ST_ER3);
                    state_next   = (state_reg == ST_ER1) ? ST_ER2 :
                                   (state_reg == ST_ER2) ? ST_ER3 : ST_IDLE;
                end
            end
            ST_ADDR: begin
                if (p_reg == len_reg) begin
                    state_next = in_tok_reg ? ST_TOKEN : ST_FLUSH;
                end else begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                p_next = p_reg + 1'b1;
                if (is_gap) begin
                    state_next = in_tok_reg ? ST_TOKEN : ST_ADDR;
                end else begin
                    cand_next    = cand_upd;
                    tok_len_next = tok_len_upd;
                    in_tok_next  = 1'b1;
                    state_next   = ST_ADDR;
                end
            end
            ST_TOKEN: begin
                if (cmds_reg == CMDS_CAP) begin
                    // drop tokens beyond the per-line limit
                    in_tok_next = 1'b0;
                    state_next  = ST_ADDR;
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_CMD;
                        m_char_next  = 8'h00;
                        m_cmd_next   = pend_code_reg;
                        m_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_code_next  = tok_code;
                    cmds_next       = cmds_reg + 1'b1;
                    in_tok_next     = 1'b0;
                    state_next      = ST_ADDR;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_CMD;
                        m_char_next  = 8'h00;
                        m_cmd_next   = pend_code_reg;
                        m_last_next  = !echo_reg;
                    end
                    pend_valid_next = 1'b0;
                    len_next        = '0;
                    state_next      = echo_reg ? ST_CR : ST_IDLE;
                end
            end
            ST_CR, ST_LF: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_ECHO;
                    m_cmd_next   = 3'd0;
                    m_char_next  = (state_reg == ST_CR) ? CHAR_CR : CHAR_LF;
                    m_last_next  = (state_reg == ST_LF);
                    state_next   = (state_reg == ST_CR) ? ST_LF : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            in_tok_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            cmds_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            in_tok_reg     <= in_tok_next;
            pend_valid_reg <= pend_valid_next;
            cmds_reg       <= cmds_next;
            m_valid_reg    <= m_valid_next;
        end
        p_reg         <= p_next;
        ch_reg        <= ch_next;
        tok_len_reg   <= tok_len_next;
        cand_reg      <= cand_next;
        pend_code_reg <= pend_code_next;
        m_kind_reg    <= m_kind_next;
        m_char_reg    <= m_char_next;
        m_cmd_reg     <= m_cmd_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_echo_char = m_char_reg;
    assign m_command   = m_cmd_reg;
    assign m_last      = m_last_reg;

endmodule
